// ===== design/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst is high.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst is high.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cra_pkg.sv =====
// Types and constants shared by the cell run allocator and its checker.
package cra_pkg;

  // Widths of the request and response fields.
  localparam int COUNT_W  = 11;
  localparam int INDEX_W  = 14;
  localparam int STATUS_W = 2;
  localparam int MARK_W   = 2;
  // Cell count of a request: (element_count + 3) / 4 fits in this width.
  localparam int N_W      = COUNT_W - 1;

  // Per-cell mark held in the mark memory.
  typedef enum logic [MARK_W-1:0] {
    MARK_FREE   = 2'd0,
    MARK_SINGLE = 2'd1,
    MARK_START  = 2'd2,
    MARK_BODY   = 2'd3
  } mark_t;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_ALLOCATED = 2'd0,
    STATUS_NO_SPACE  = 2'd1,
    STATUS_FREED     = 2'd2,
    STATUS_IGNORED   = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SEARCH,
    S_MARK,
    S_WALK,
    S_SWEEP,
    S_EMIT
  } state_t;

endpackage

// ===== design/cell_run_allocator.sv =====
// Next-fit cell run allocator built around a single-read, single-write mark memory.
//
// After reset the block clears every cell of the mark memory, with in_stall high,
// before it takes the first request. A request that passes its range check then
// walks the marks one cell per cycle through the memory's one read port, whose
// read data is registered. An allocate is accepted, scans cells in one or two
// search passes (a pass ends at the pool end or at the first fit), writes the
// start and body cells of the run, and posts the response. A free walks back over
// body cells to the run start, clears that start and the body cells after it, and
// posts the response. The response sits in an output register, so a new request
// is accepted while the last response waits.
module cell_run_allocator #(
  parameter int POOL_CELLS   = 16384,
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic [cra_pkg::COUNT_W-1:0]    element_count,
  input  logic [cra_pkg::INDEX_W-1:0]    cell_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cra_pkg::STATUS_W-1:0]   status,
  output logic [cra_pkg::INDEX_W-1:0]    start_cell
);

  localparam int AW = $clog2(POOL_CELLS);
  localparam logic [AW:0] POOL_END  = (AW+1)'(POOL_CELLS);
  localparam logic [AW:0] POOL_LAST = (AW+1)'(POOL_CELLS - 1);

  // Mark memory and its ports.
  logic [cra_pkg::MARK_W-1:0] mem [0:POOL_CELLS-1];
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  cra_pkg::mark_t             mem_wdata;
  logic [AW-1:0]              mem_raddr;
  logic [cra_pkg::MARK_W-1:0] rdata;

  // Control and working registers.
  cra_pkg::state_t            state, state_next;
  logic [AW:0]                iss, iss_next;
  logic                       more, more_next;
  logic                       first, first_next;
  logic                       pass, pass_next;
  logic                       rd_valid, rd_valid_next;
  logic [AW-1:0]              rd_addr, rd_addr_next;
  logic [cra_pkg::N_W-1:0]    run, run_next;
  logic [cra_pkg::N_W-1:0]    n_cells, n_cells_next;
  logic [cra_pkg::N_W-1:0]    mcnt, mcnt_next;
  logic [AW-1:0]              wptr, wptr_next;
  logic [AW:0]                rover, rover_next;
  cra_pkg::status_t           res_status, res_status_next;
  logic [cra_pkg::INDEX_W-1:0] res_start, res_start_next;
  logic                       out_valid_next;
  logic [cra_pkg::STATUS_W-1:0] status_next;
  logic [cra_pkg::INDEX_W-1:0] start_cell_next;

  // Request decode helpers.
  logic [cra_pkg::COUNT_W:0]  cnt_up;
  logic [cra_pkg::N_W-1:0]    n_req;
  logic [cra_pkg::N_W-1:0]    run_inc;
  logic [AW:0]                pos;

  assign cnt_up    = (cra_pkg::COUNT_W+1)'(element_count) + (cra_pkg::COUNT_W+1)'(3);
  assign n_req     = (cnt_up[cra_pkg::COUNT_W:2] == '0) ? cra_pkg::N_W'(1)
                                                        : cnt_up[cra_pkg::COUNT_W:2];
  assign run_inc   = run + cra_pkg::N_W'(1);
  assign pos       = (AW+1)'(rd_addr) + (AW+1)'(1) - (AW+1)'(n_cells);
  assign mem_raddr = iss[AW-1:0];

  // Synchronous mark memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // State and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cra_pkg::S_CLEAR;
      iss       <= '0;
      more      <= 1'b0;
      first     <= 1'b0;
      pass      <= 1'b0;
      rd_valid  <= 1'b0;
      rover     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      iss       <= iss_next;
      more      <= more_next;
      first     <= first_next;
      pass      <= pass_next;
      rd_valid  <= rd_valid_next;
      rover     <= rover_next;
      out_valid <= out_valid_next;
    end
    rd_addr    <= rd_addr_next;
    run        <= run_next;
    n_cells    <= n_cells_next;
    mcnt       <= mcnt_next;
    wptr       <= wptr_next;
    res_status <= res_status_next;
    res_start  <= res_start_next;
    status     <= status_next;
    start_cell <= start_cell_next;
  end

  // Next state, memory accesses and response.
  always_comb begin
    state_next      = state;
    iss_next        = iss;
    more_next       = more;
    first_next      = first;
    pass_next       = pass;
    rd_valid_next   = 1'b0;
    rd_addr_next    = iss[AW-1:0];
    run_next        = run;
    n_cells_next    = n_cells;
    mcnt_next       = mcnt;
    wptr_next       = wptr;
    rover_next      = rover;
    res_status_next = res_status;
    res_start_next  = res_start;
    out_valid_next  = out_valid && out_stall;
    status_next     = status;
    start_cell_next = start_cell;
    mem_we          = 1'b0;
    mem_waddr       = rd_addr;
    mem_wdata       = cra_pkg::MARK_FREE;
    in_stall        = (state != cra_pkg::S_IDLE);

    case (state)
      // Sweep every cell to free after reset.
      cra_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = iss[AW-1:0];
        iss_next  = iss + (AW+1)'(1);
        if (iss == POOL_LAST) begin
          iss_next   = '0;
          state_next = cra_pkg::S_IDLE;
        end
      end

      // Take a request transaction and set up the search or walk, or answer an out-of-range one directly.
      cra_pkg::S_IDLE: begin
        if (in_valid) begin
          res_start_next = '0;
          if (!kind) begin
            if (32'(element_count) > 32'(MAX_ELEMENTS)) begin
              res_status_next = cra_pkg::STATUS_NO_SPACE;
              state_next      = cra_pkg::S_EMIT;
            end else begin
              n_cells_next = n_req;
              iss_next     = rover;
              run_next     = '0;
              pass_next    = 1'b0;
              state_next   = cra_pkg::S_SEARCH;
            end
          end else begin
            if (32'(cell_index) >= 32'(POOL_CELLS)) begin
              res_status_next = cra_pkg::STATUS_IGNORED;
              state_next      = cra_pkg::S_EMIT;
            end else begin
              iss_next   = (AW+1)'(cell_index);
              more_next  = 1'b1;
              first_next = 1'b1;
              state_next = cra_pkg::S_WALK;
            end
          end
        end
      end

      // Stream marks upward from the rover, counting free cells in a row.
      cra_pkg::S_SEARCH: begin
        if (iss < POOL_END) begin
          rd_valid_next = 1'b1;
          iss_next      = iss + (AW+1)'(1);
        end
        if (rd_valid) begin
          if (rdata == cra_pkg::MARK_FREE) begin
            run_next = run_inc;
            if (run_inc == n_cells) begin
              wptr_next      = pos[AW-1:0];
              mcnt_next      = '0;
              res_start_next = cra_pkg::INDEX_W'(pos);
              rd_valid_next  = 1'b0;
              state_next     = cra_pkg::S_MARK;
            end
          end else begin
            run_next = '0;
          end
        end else if (iss >= POOL_END) begin
          // The pass reached the pool end with nothing in flight.
          if (!pass) begin
            rover_next = '0;
            iss_next   = '0;
            run_next   = '0;
            pass_next  = 1'b1;
          end else begin
            res_status_next = cra_pkg::STATUS_NO_SPACE;
            res_start_next  = '0;
            state_next      = cra_pkg::S_EMIT;
          end
        end
      end

      // Write the run start, then its body cells, one per cycle.
      cra_pkg::S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = wptr;
        mem_wdata = (mcnt == '0) ? cra_pkg::MARK_START : cra_pkg::MARK_BODY;
        if (mcnt == n_cells - cra_pkg::N_W'(1)) begin
          rover_next      = (AW+1)'(wptr) + (AW+1)'(1);
          res_status_next = cra_pkg::STATUS_ALLOCATED;
          state_next      = cra_pkg::S_EMIT;
        end else begin
          mcnt_next = mcnt + cra_pkg::N_W'(1);
          wptr_next = wptr + AW'(1);
        end
      end

      // Walk down from the named cell to the start of its run.
      cra_pkg::S_WALK: begin
        if (more) begin
          rd_valid_next = 1'b1;
          if (iss == '0) begin
            more_next = 1'b0;
          end else begin
            iss_next = iss - (AW+1)'(1);
          end
        end
        if (rd_valid) begin
          first_next = 1'b0;
          if (first && rdata == cra_pkg::MARK_SINGLE) begin
            mem_we          = 1'b1;
            rd_valid_next   = 1'b0;
            res_status_next = cra_pkg::STATUS_FREED;
            state_next      = cra_pkg::S_EMIT;
          end else if (rdata == cra_pkg::MARK_BODY && rd_addr != '0) begin
            // Keep walking down.
          end else if (rdata == cra_pkg::MARK_START) begin
            mem_we        = 1'b1;
            iss_next      = (AW+1)'(rd_addr) + (AW+1)'(1);
            rd_valid_next = 1'b0;
            state_next    = cra_pkg::S_SWEEP;
          end else begin
            rd_valid_next   = 1'b0;
            res_status_next = cra_pkg::STATUS_IGNORED;
            state_next      = cra_pkg::S_EMIT;
          end
        end
      end

      // Clear the body cells that follow the run start.
      cra_pkg::S_SWEEP: begin
        if (iss < POOL_END) begin
          rd_valid_next = 1'b1;
          iss_next      = iss + (AW+1)'(1);
        end
        if (rd_valid) begin
          if (rdata == cra_pkg::MARK_BODY) begin
            mem_we = 1'b1;
          end else begin
            rd_valid_next   = 1'b0;
            res_status_next = cra_pkg::STATUS_FREED;
            state_next      = cra_pkg::S_EMIT;
          end
        end else if (iss >= POOL_END) begin
          res_status_next = cra_pkg::STATUS_FREED;
          state_next      = cra_pkg::S_EMIT;
        end
      end

      // Hand the response to the output register once it is free.
      cra_pkg::S_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next  = 1'b1;
          status_next     = res_status;
          start_cell_next = res_start;
          state_next      = cra_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = cra_pkg::S_CLEAR;
        iss_next   = '0;
      end
    endcase
  end

endmodule

// ===== design/cra_checker.sv =====
// Port-level checker for the cell run allocator and its bind statement.
`include "assert_macros.svh"

module cra_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [cra_pkg::STATUS_W-1:0] status,
  input logic [cra_pkg::INDEX_W-1:0]  start_cell
);

  // A stalled response stays put.
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(start_cell), "stalled response changed")

  // Only an allocation reports a start cell.
  `ASSERT_IMPLY(a_start_zero, out_valid && status != cra_pkg::STATUS_ALLOCATED, start_cell == '0, "start cell set on a non-allocate response")

  // The clearing pass holds off requests right after reset.
  `ASSERT_IMPLY(a_clear_stall, $past(rst), in_stall, "request taken during the clearing pass")

  // Requests are handled one at a time.
  `ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second request taken while busy")

endmodule

bind cell_run_allocator cra_checker u_cra_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the cell run allocator, driven by directed and random transactions.
module testbench;

  localparam int POOL_SIZE      = 16384;
  localparam int MAX_ELEMS      = 1024;
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_FREE    = 1'b1;
  localparam int TARGET_ITEMS   = 950;
  localparam int TAIL_FROM      = 830;
  localparam int LIVE_CAP       = 2500;
  localparam int HOLD_AT        = 500;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 100;

  // Short names for the response codes used in the stimulus table.
  localparam cra_pkg::status_t ST_ALLOC = cra_pkg::STATUS_ALLOCATED;
  localparam cra_pkg::status_t ST_NOSPC = cra_pkg::STATUS_NO_SPACE;
  localparam cra_pkg::status_t ST_FREED = cra_pkg::STATUS_FREED;
  localparam cra_pkg::status_t ST_IGN   = cra_pkg::STATUS_IGNORED;

  // Expected response of one transaction.
  typedef struct packed {
    cra_pkg::status_t            code;
    logic [cra_pkg::INDEX_W-1:0] first;
  } outcome_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic                        kind;
    logic [cra_pkg::COUNT_W-1:0] cnt;
    logic [cra_pkg::INDEX_W-1:0] idx;
    bit                          fixed;
    cra_pkg::status_t            code;
    logic [cra_pkg::INDEX_W-1:0] first;
  } req_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = KIND_ALLOC;
  logic [cra_pkg::COUNT_W-1:0] element_count = '0;
  logic [cra_pkg::INDEX_W-1:0] cell_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [cra_pkg::STATUS_W-1:0] status;
  logic [cra_pkg::INDEX_W-1:0] start_cell;

  // Typed expectation that travels with a directed transaction.
  bit row_fixed = 1'b0;
  cra_pkg::status_t row_code = cra_pkg::STATUS_ALLOCATED;
  logic [cra_pkg::INDEX_W-1:0] row_first = '0;

  // Predictor state: one mark per cell, the roving pointer and the live runs.
  cra_pkg::mark_t pool_marks [POOL_SIZE];
  int rover_pos = 0;
  int run_starts[$];
  int run_lens[$];
  int live_cells = 0;
  cra_pkg::status_t last_code = cra_pkg::STATUS_ALLOCATED;

  outcome_t outcome_q[$];
  int served = 0;
  int results_seen = 0;
  int errors = 0;
  int idle_cycles = 0;
  bit tail = 1'b0;
  req_row_t opening_reqs[$];

  cell_run_allocator #(
    .POOL_CELLS   (POOL_SIZE),
    .MAX_ELEMENTS (MAX_ELEMS)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .element_count (element_count),
    .cell_index    (cell_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .start_cell    (start_cell)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // First cell of a free run of n cells at or after from, or POOL_SIZE if none fits.
  function automatic int find_free_run(int from, int n);
    int run_len;
    run_len = 0;
    for (int i = from; i < POOL_SIZE; i++) begin
      if (pool_marks[i] == cra_pkg::MARK_FREE) begin
        run_len++;
        if (run_len == n) return i + 1 - n;
      end else begin
        run_len = 0;
      end
    end
    return POOL_SIZE;
  endfunction

  // Next-fit allocation with one retry from cell zero.
  function automatic void predict_alloc(int count, output cra_pkg::status_t code,
                                        output int first);
    int n;
    int pos;
    first = 0;
    code = cra_pkg::STATUS_NO_SPACE;
    if (count > MAX_ELEMS) return;
    n = (count + 3) / 4;
    if (n == 0) n = 1;
    pos = find_free_run(rover_pos, n);
    if (pos >= POOL_SIZE) begin
      rover_pos = 0;
      pos = find_free_run(0, n);
      if (pos >= POOL_SIZE) return;
    end
    pool_marks[pos] = cra_pkg::MARK_START;
    for (int j = 1; j < n; j++) pool_marks[pos + j] = cra_pkg::MARK_BODY;
    rover_pos = pos + n;
    first = pos;
    code = cra_pkg::STATUS_ALLOCATED;
    run_starts.push_back(pos);
    run_lens.push_back(n);
    live_cells += n;
  endfunction

  // Release the run holding a cell; a body cell is walked back to its start.
  function automatic void predict_release(int idx, output cra_pkg::status_t code);
    int pos;
    int head;
    code = cra_pkg::STATUS_IGNORED;
    if (idx >= POOL_SIZE) return;
    if (pool_marks[idx] == cra_pkg::MARK_FREE) return;
    if (pool_marks[idx] == cra_pkg::MARK_SINGLE) begin
      pool_marks[idx] = cra_pkg::MARK_FREE;
      code = cra_pkg::STATUS_FREED;
      return;
    end
    pos = idx;
    while (pos > 0 && pool_marks[pos] == cra_pkg::MARK_BODY) pos--;
    if (pool_marks[pos] != cra_pkg::MARK_START) return;
    head = pos;
    pool_marks[pos] = cra_pkg::MARK_FREE;
    pos++;
    while (pos < POOL_SIZE && pool_marks[pos] == cra_pkg::MARK_BODY) begin
      pool_marks[pos] = cra_pkg::MARK_FREE;
      pos++;
    end
    code = cra_pkg::STATUS_FREED;
    // Drop the run from the list of live runs.
    for (int k = 0; k < run_starts.size(); k++) begin
      if (run_starts[k] == head) begin
        live_cells -= run_lens[k];
        run_starts.delete(k);
        run_lens.delete(k);
        break;
      end
    end
  endfunction

  // Predict accepted requests, check accepted responses, and watch for a hang.
  always @(posedge clk) begin
    cra_pkg::status_t pred_code;
    int pred_first;
    outcome_t want;
    bit took_in;
    bit took_out;
    if (!rst) begin
      took_in = in_valid && !in_stall;
      took_out = out_valid && !out_stall;
      if (took_in) begin
        pred_first = 0;
        if (kind == KIND_ALLOC) predict_alloc(int'(element_count), pred_code, pred_first);
        else predict_release(int'(cell_index), pred_code);
        if (pred_code != cra_pkg::STATUS_IGNORED) served++;
        last_code = pred_code;
        if (row_fixed) outcome_q.push_back('{row_code, row_first});
        else outcome_q.push_back('{pred_code, cra_pkg::INDEX_W'(pred_first)});
      end
      if (took_out) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected response: status %0d start %0d", status, start_cell);
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.code || start_cell !== want.first) begin
            errors++;
            if (errors <= 10)
              $display("response %0d: expected status %0d start %0d, got status %0d start %0d",
                       results_seen, want.code, want.first, status, start_cell);
          end
        end
      end
      if (took_in || took_out) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Response side: random stall bursts, calm windows and one long hold-off.
  initial begin
    int burst_left;
    int hold_left;
    bit hold_done;
    bit rx_calm;
    burst_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      rx_calm = tail || ((results_seen / 110) % 4 == 2);
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall = 1'b1;
      end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 14);
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Offer one request, with an optional idle burst first, and wait until it is taken.
  task automatic send_req(input logic k, input logic [cra_pkg::COUNT_W-1:0] cnt,
                          input logic [cra_pkg::INDEX_W-1:0] idx, input bit fixed,
                          input cra_pkg::status_t code,
                          input logic [cra_pkg::INDEX_W-1:0] first);
    if (!tail && ((served / 90) % 4 != 1) && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid = 1'b1;
    kind = k;
    element_count = cnt;
    cell_index = idx;
    row_fixed = fixed;
    row_code = code;
    row_first = first;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Free one live run through a random cell inside it.
  task automatic release_live();
    int slot;
    int pick_cell;
    slot = $urandom_range(0, run_starts.size() - 1);
    pick_cell = run_starts[slot] + $urandom_range(0, run_lens[slot] - 1);
    send_req(KIND_FREE, cra_pkg::COUNT_W'($urandom), cra_pkg::INDEX_W'(pick_cell), 1'b0,
             cra_pkg::STATUS_FREED, '0);
  endtask

  task automatic release_all();
    while (run_starts.size() > 0) release_live();
  endtask

  // Random mix: mostly small allocations and frees of live runs, some noise.
  task automatic random_req();
    int unsigned pick;
    int unsigned sub;
    logic [cra_pkg::COUNT_W-1:0] cnt;
    logic [cra_pkg::INDEX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    cnt = cra_pkg::COUNT_W'($urandom);
    idx = cra_pkg::INDEX_W'($urandom);
    if (live_cells > LIVE_CAP && run_starts.size() > 0) pick = 60;
    if (pick >= 45 && pick < 90 && run_starts.size() == 0) pick = 0;
    if (pick < 45) begin
      sub = $urandom_range(0, 99);
      if (sub < 70) cnt = cra_pkg::COUNT_W'($urandom_range(0, 64));
      else if (sub < 88) cnt = cra_pkg::COUNT_W'($urandom_range(65, MAX_ELEMS));
      else if (sub < 94) cnt = cra_pkg::COUNT_W'($urandom_range(MAX_ELEMS + 1, 2047));
      else if (sub < 97) cnt = '0;
      else cnt = cra_pkg::COUNT_W'(MAX_ELEMS);
      send_req(KIND_ALLOC, cnt, idx, 1'b0, cra_pkg::STATUS_ALLOCATED, '0);
    end else if (pick < 90) begin
      release_live();
    end else begin
      send_req(KIND_FREE, cnt, idx, 1'b0, cra_pkg::STATUS_IGNORED, '0);
    end
  endtask

  // Fill the pool with largest runs until it is exhausted, reopen holes, then empty it.
  task automatic fill_pool();
    release_all();
    send_req(KIND_ALLOC, cra_pkg::COUNT_W'($urandom_range(0, MAX_ELEMS)),
             cra_pkg::INDEX_W'($urandom), 1'b0, cra_pkg::STATUS_ALLOCATED, '0);
    do begin
      send_req(KIND_ALLOC, cra_pkg::COUNT_W'(MAX_ELEMS), cra_pkg::INDEX_W'($urandom), 1'b0,
               cra_pkg::STATUS_ALLOCATED, '0);
    end while (last_code == cra_pkg::STATUS_ALLOCATED);
    repeat (2) release_live();
    repeat (3) begin
      send_req(KIND_ALLOC, cra_pkg::COUNT_W'(MAX_ELEMS), cra_pkg::INDEX_W'($urandom), 1'b0,
               cra_pkg::STATUS_ALLOCATED, '0);
    end
    release_all();
  endtask

  // Main sequence: reset, directed table, random phases with two fills, then drain.
  initial begin
    foreach (pool_marks[i]) pool_marks[i] = cra_pkg::MARK_FREE;

    // Directed rows; the typed ones start from an empty pool with the rover at zero.
    opening_reqs.push_back('{KIND_ALLOC, 11'd0,    14'h3FFF,  1'b1, ST_ALLOC, 14'd0});
    opening_reqs.push_back('{KIND_ALLOC, 11'd1,    14'd0,     1'b1, ST_ALLOC, 14'd1});
    opening_reqs.push_back('{KIND_ALLOC, 11'd4,    14'd0,     1'b0, ST_ALLOC, 14'd0});
    opening_reqs.push_back('{KIND_ALLOC, 11'd5,    14'h2AAA,  1'b0, ST_ALLOC, 14'd0});
    opening_reqs.push_back('{KIND_ALLOC, 11'd1024, 14'd0,     1'b1, ST_ALLOC, 14'd5});
    opening_reqs.push_back('{KIND_ALLOC, 11'd1025, 14'd0,     1'b1, ST_NOSPC, 14'd0});
    opening_reqs.push_back('{KIND_ALLOC, 11'd2047, 14'h3FFF,  1'b1, ST_NOSPC, 14'd0});
    opening_reqs.push_back('{KIND_FREE,  11'd2047, 14'd16383, 1'b1, ST_IGN,   14'd0});
    opening_reqs.push_back('{KIND_FREE,  11'd0,    14'd0,     1'b1, ST_FREED, 14'd0});
    opening_reqs.push_back('{KIND_FREE,  11'h555,  14'd0,     1'b1, ST_IGN,   14'd0});
    opening_reqs.push_back('{KIND_FREE,  11'd0,    14'd100,   1'b1, ST_FREED, 14'd0});
    opening_reqs.push_back('{KIND_FREE,  11'd0,    14'd5,     1'b1, ST_IGN,   14'd0});
    opening_reqs.push_back('{KIND_FREE,  11'd0,    14'd260,   1'b0, ST_IGN,   14'd0});
    opening_reqs.push_back('{KIND_FREE,  11'h2AA,  14'd4,     1'b0, ST_FREED, 14'd0});
    opening_reqs.push_back('{KIND_FREE,  11'd0,    14'd2,     1'b0, ST_FREED, 14'd0});
    opening_reqs.push_back('{KIND_ALLOC, 11'd3,    14'h1555,  1'b0, ST_ALLOC, 14'd0});
    opening_reqs.push_back('{KIND_ALLOC, 11'd1020, 14'd0,     1'b0, ST_ALLOC, 14'd0});
    opening_reqs.push_back('{KIND_FREE,  11'd0,    14'd516,   1'b0, ST_FREED, 14'd0});
    opening_reqs.push_back('{KIND_ALLOC, 11'd12,   14'd0,     1'b0, ST_ALLOC, 14'd0});
    opening_reqs.push_back('{KIND_FREE,  11'd0,    14'd1,     1'b0, ST_FREED, 14'd0});
    opening_reqs.push_back('{KIND_FREE,  11'd0,    14'd517,   1'b0, ST_FREED, 14'd0});
    opening_reqs.push_back('{KIND_FREE,  11'd0,    14'd261,   1'b0, ST_FREED, 14'd0});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (opening_reqs[i]) begin
      send_req(opening_reqs[i].kind, opening_reqs[i].cnt, opening_reqs[i].idx,
               opening_reqs[i].fixed, opening_reqs[i].code, opening_reqs[i].first);
    end

    while (served < 300) random_req();
    fill_pool();
    while (served < 650) random_req();
    fill_pool();
    while (served < TARGET_ITEMS) begin
      if (served >= TAIL_FROM) tail = 1'b1;
      random_req();
    end
    in_valid = 1'b0;
    row_fixed = 1'b0;

    // Let every response arrive, then watch for stray ones.
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/cra_pkg.sv
design/cell_run_allocator.sv
design/cra_checker.sv
sim/testbench.sv
